@@ design/ysa_pkg.sv @@
// Shared constants for the YUV saturation adjust pipeline.
package ysa_pkg;

  localparam int GAIN_W      = 12;
  localparam int GAIN_RESET  = 256;
  localparam int COEF_W      = 13;
  localparam int FWD_SHIFT   = 10;
  localparam int OUT_SHIFT   = 28;
  localparam int Y_SHIFT     = OUT_SHIFT - FWD_SHIFT;

  // forward matrix, Q2.10
  localparam int C_YR = 306;
  localparam int C_YG = 601;
  localparam int C_YB = 117;
  localparam int C_UR = -151;
  localparam int C_UG = -296;
  localparam int C_UB = 446;
  localparam int C_VR = 630;
  localparam int C_VG = -527;
  localparam int C_VB = -102;

  // inverse matrix, Q2.10, Y weight is one
  localparam int C_RV = 1167;
  localparam int C_GU = -404;
  localparam int C_GV = -595;
  localparam int C_BU = 2081;

endpackage

@@ design/ysa_fwd.sv @@
// RGB to YUV forward matrix stage, registered.
module ysa_fwd import ysa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic [PIXEL_BITS-1:0]        red,
  input  logic [PIXEL_BITS-1:0]        green,
  input  logic [PIXEL_BITS-1:0]        blue,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic signed [PIXEL_BITS+10:0] y_out,
  output logic signed [PIXEL_BITS+10:0] u_out,
  output logic signed [PIXEL_BITS+10:0] v_out
);

  localparam int CW = PIXEL_BITS + 11;

  logic signed [CW-1:0] r_s, g_s, b_s;
  logic signed [CW-1:0] y_nxt, u_nxt, v_nxt;
  logic signed [CW-1:0] y_r, u_r, v_r;
  logic                 vld_r;

  assign r_s = $signed({{(CW-PIXEL_BITS){1'b0}}, red});
  assign g_s = $signed({{(CW-PIXEL_BITS){1'b0}}, green});
  assign b_s = $signed({{(CW-PIXEL_BITS){1'b0}}, blue});

  assign y_nxt = $signed(CW'(C_YR)) * r_s + $signed(CW'(C_YG)) * g_s
               + $signed(CW'(C_YB)) * b_s;
  assign u_nxt = $signed(CW'(C_UR)) * r_s + $signed(CW'(C_UG)) * g_s
               + $signed(CW'(C_UB)) * b_s;
  assign v_nxt = $signed(CW'(C_VR)) * r_s + $signed(CW'(C_VG)) * g_s
               + $signed(CW'(C_VB)) * b_s;

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      y_r <= y_nxt;
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign out_vld = vld_r;
  assign y_out   = y_r;
  assign u_out   = u_r;
  assign v_out   = v_r;

endmodule

@@ design/ysa_gain.sv @@
// Chroma gain stage: scales U and V by the saturation gain, registered.
module ysa_gain import ysa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [GAIN_W-1:0]      gain,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic signed [PIXEL_BITS+10:0] y_in,
  input  logic signed [PIXEL_BITS+10:0] u_in,
  input  logic signed [PIXEL_BITS+10:0] v_in,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic signed [PIXEL_BITS+10:0] y_out,
  output logic signed [PIXEL_BITS+GAIN_W+10:0] u_out,
  output logic signed [PIXEL_BITS+GAIN_W+10:0] v_out
);

  localparam int CW = PIXEL_BITS + 11;
  localparam int MW = CW + GAIN_W;

  logic signed [MW-1:0] u_nxt, v_nxt, g_ext;
  logic signed [MW-1:0] u_r, v_r;
  logic signed [CW-1:0] y_r;
  logic                 vld_r;

  assign g_ext = MW'(gain);
  assign u_nxt = MW'(u_in) * g_ext;
  assign v_nxt = MW'(v_in) * g_ext;

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      y_r <= y_in;
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign out_vld = vld_r;
  assign y_out   = y_r;
  assign u_out   = u_r;
  assign v_out   = v_r;

endmodule

@@ design/ysa_inv.sv @@
// Inverse matrix products stage, registered; luma is aligned and pre-rounded.
module ysa_inv import ysa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  logic signed [PIXEL_BITS+10:0]        y_in,
  input  logic signed [PIXEL_BITS+GAIN_W+10:0] u_in,
  input  logic signed [PIXEL_BITS+GAIN_W+10:0] v_in,
  output logic                                 out_vld,
  input  logic                                 out_rdy,
  output logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] y_out,
  output logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] rv_out,
  output logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] gu_out,
  output logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] gv_out,
  output logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] bu_out
);

  localparam int PW = PIXEL_BITS + GAIN_W + COEF_W + 11;

  logic signed [PW-1:0] y_nxt, rv_nxt, gu_nxt, gv_nxt, bu_nxt;
  logic signed [PW-1:0] y_r, rv_r, gu_r, gv_r, bu_r;
  logic                 vld_r;

  // half an output LSB folded into luma for round-half-up
  assign y_nxt  = (PW'(y_in) <<< Y_SHIFT) + (PW'(1) <<< (OUT_SHIFT - 1));
  assign rv_nxt = PW'(v_in) * $signed(PW'(C_RV));
  assign gu_nxt = PW'(u_in) * $signed(PW'(C_GU));
  assign gv_nxt = PW'(v_in) * $signed(PW'(C_GV));
  assign bu_nxt = PW'(u_in) * $signed(PW'(C_BU));

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      y_r  <= y_nxt;
      rv_r <= rv_nxt;
      gu_r <= gu_nxt;
      gv_r <= gv_nxt;
      bu_r <= bu_nxt;
    end
  end

  assign out_vld = vld_r;
  assign y_out   = y_r;
  assign rv_out  = rv_r;
  assign gu_out  = gu_r;
  assign gv_out  = gv_r;
  assign bu_out  = bu_r;

endmodule

@@ design/ysa_out.sv @@
// Channel sums, then shift, clamp and clip flag; two register stages.
module ysa_out import ysa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_vld,
  output logic                                        in_rdy,
  input  logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] y_in,
  input  logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] rv_in,
  input  logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] gu_in,
  input  logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] gv_in,
  input  logic signed [PIXEL_BITS+GAIN_W+COEF_W+10:0] bu_in,
  output logic                                        out_vld,
  input  logic                                        out_rdy,
  output logic [PIXEL_BITS-1:0]                       red,
  output logic [PIXEL_BITS-1:0]                       green,
  output logic [PIXEL_BITS-1:0]                       blue,
  output logic                                        clipped
);

  localparam int PW = PIXEL_BITS + GAIN_W + COEF_W + 11;
  localparam int SW = PW + 2;
  localparam int QW = SW - OUT_SHIFT;

  logic signed [SW-1:0] rs_nxt, gs_nxt, bs_nxt;
  logic signed [SW-1:0] rs_r, gs_r, bs_r;
  logic                 sum_vld_r;
  logic                 sum_rdy;

  logic signed [QW-1:0] rq, gq, bq;
  logic [PIXEL_BITS-1:0] r_nxt, g_nxt, b_nxt;
  logic                 rc, gc, bc;
  logic [PIXEL_BITS-1:0] r_r, g_r, b_r;
  logic                 clip_r;
  logic                 out_vld_r;
  logic                 out_rdy_int;

  // green coefficients are negative already, so both products add
  assign rs_nxt = SW'(y_in) + SW'(rv_in);
  assign gs_nxt = SW'(y_in) + SW'(gu_in) + SW'(gv_in);
  assign bs_nxt = SW'(y_in) + SW'(bu_in);

  assign out_rdy_int = !out_vld_r || out_rdy;
  assign sum_rdy     = !sum_vld_r || out_rdy_int;
  assign in_rdy      = sum_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (sum_rdy) begin
      sum_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_rdy && in_vld) begin
      rs_r <= rs_nxt;
      gs_r <= gs_nxt;
      bs_r <= bs_nxt;
    end
  end

  // arithmetic shift floors; rounding offset was added upstream
  assign rq = QW'(rs_r >>> OUT_SHIFT);
  assign gq = QW'(gs_r >>> OUT_SHIFT);
  assign bq = QW'(bs_r >>> OUT_SHIFT);

  function automatic logic [PIXEL_BITS:0] clamp_ch(input logic signed [QW-1:0] q);
    logic [PIXEL_BITS:0] res;
    if (q < 0) begin
      res = {1'b1, {PIXEL_BITS{1'b0}}};
    end else if (q > $signed(QW'({PIXEL_BITS{1'b1}}))) begin
      res = {1'b1, {PIXEL_BITS{1'b1}}};
    end else begin
      res = {1'b0, q[PIXEL_BITS-1:0]};
    end
    return res;
  endfunction

  assign {rc, r_nxt} = clamp_ch(rq);
  assign {gc, g_nxt} = clamp_ch(gq);
  assign {bc, b_nxt} = clamp_ch(bq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy_int) begin
      out_vld_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy_int && sum_vld_r) begin
      r_r    <= r_nxt;
      g_r    <= g_nxt;
      b_r    <= b_nxt;
      clip_r <= rc | gc | bc;
    end
  end

  assign out_vld = out_vld_r;
  assign red     = r_r;
  assign green   = g_r;
  assign blue    = b_r;
  assign clipped = clip_r;

endmodule

@@ design/yuv_saturation_adjust_unit.sv @@
// Register stages from input beat to output beat: forward matrix, gain,
// inverse products, channel sums, shift/clamp, one register stage each.
// Throughput: one pixel per cycle; each stage holds its beat under stall and
// refills as soon as the stage after it moves.
// Reset (synchronous, rst_n low): clears all stage valid bits and loads the
// saturation gain with 256 (unity).
module yuv_saturation_adjust_unit import ysa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [GAIN_W-1:0]     cfg_saturation_gain,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_red_in,
  input  logic [PIXEL_BITS-1:0] in_green_in,
  input  logic [PIXEL_BITS-1:0] in_blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_red_out,
  output logic [PIXEL_BITS-1:0] out_green_out,
  output logic [PIXEL_BITS-1:0] out_blue_out,
  output logic                  out_clipped
);

  localparam int CW = PIXEL_BITS + 11;
  localparam int MW = CW + GAIN_W;
  localparam int PW = MW + COEF_W;

  logic signed [GAIN_W-1:0] gain_r;

  logic                 fwd_rdy, fwd_vld;
  logic signed [CW-1:0] fy, fu, fv;
  logic                 gn_rdy, gn_vld;
  logic signed [CW-1:0] gy;
  logic signed [MW-1:0] gu, gv;
  logic                 inv_rdy, inv_vld;
  logic signed [PW-1:0] iy, irv, igu, igv, ibu;
  logic                 out_rdy_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we) begin
      gain_r <= cfg_saturation_gain;
    end
  end

  ysa_fwd #(.PIXEL_BITS(PIXEL_BITS)) u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (fwd_rdy),
    .red     (in_red_in),
    .green   (in_green_in),
    .blue    (in_blue_in),
    .out_vld (fwd_vld),
    .out_rdy (gn_rdy),
    .y_out   (fy),
    .u_out   (fu),
    .v_out   (fv)
  );

  ysa_gain #(.PIXEL_BITS(PIXEL_BITS)) u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .gain    (gain_r),
    .in_vld  (fwd_vld),
    .in_rdy  (gn_rdy),
    .y_in    (fy),
    .u_in    (fu),
    .v_in    (fv),
    .out_vld (gn_vld),
    .out_rdy (inv_rdy),
    .y_out   (gy),
    .u_out   (gu),
    .v_out   (gv)
  );

  ysa_inv #(.PIXEL_BITS(PIXEL_BITS)) u_inv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (gn_vld),
    .in_rdy  (inv_rdy),
    .y_in    (gy),
    .u_in    (gu),
    .v_in    (gv),
    .out_vld (inv_vld),
    .out_rdy (out_rdy_s),
    .y_out   (iy),
    .rv_out  (irv),
    .gu_out  (igu),
    .gv_out  (igv),
    .bu_out  (ibu)
  );

  ysa_out #(.PIXEL_BITS(PIXEL_BITS)) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (inv_vld),
    .in_rdy  (out_rdy_s),
    .y_in    (iy),
    .rv_in   (irv),
    .gu_in   (igu),
    .gv_in   (igv),
    .bu_in   (ibu),
    .out_vld (out_valid),
    .out_rdy (!out_stall),
    .red     (out_red_out),
    .green   (out_green_out),
    .blue    (out_blue_out),
    .clipped (out_clipped)
  );

  assign in_stall = !fwd_rdy;

endmodule

@@ sim/saturation_adjust_checker.sv @@
// Checker for the saturation adjust unit: predicts each pixel and compares result beats.
module saturation_adjust_checker import ysa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_saturation_gain,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_red_out,
  input  logic [7:0]        out_green_out,
  input  logic [7:0]        out_blue_out,
  input  logic              out_clipped,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clipped;
  } pixel_result_t;

  pixel_result_t            expected_pixels[$];
  logic signed [GAIN_W-1:0] gain_q;
  int                       mismatch_cnt = 0;

  assign mismatches = mismatch_cnt;

  // round half up at 2^28, then clamp to the 8-bit range
  function automatic logic [7:0] round_to_pixel(input longint acc, inout logic clip);
    longint q;
    q = (acc + (64'sd1 <<< 27)) >>> 28;
    if (q < 0) begin
      clip = 1'b1;
      return 8'd0;
    end
    if (q > 255) begin
      clip = 1'b1;
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic pixel_result_t adjust_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b,
                                                 input logic signed [GAIN_W-1:0] gain);
    longint        rl, gl, bl, gn, y10, u10, v10, u18, v18, y28;
    logic          clip;
    pixel_result_t res;
    rl   = longint'(r);
    gl   = longint'(g);
    bl   = longint'(b);
    gn   = longint'(gain);
    y10  = 306 * rl + 601 * gl + 117 * bl;
    u10  = -151 * rl - 296 * gl + 446 * bl;
    v10  = 630 * rl - 527 * gl - 102 * bl;
    u18  = u10 * gn;
    v18  = v10 * gn;
    y28  = y10 <<< 18;
    clip = 1'b0;
    res.red     = round_to_pixel(y28 + 1167 * v18, clip);
    res.green   = round_to_pixel(y28 - 404 * u18 - 595 * v18, clip);
    res.blue    = round_to_pixel(y28 + 2081 * u18, clip);
    res.clipped = clip;
    return res;
  endfunction

  always @(posedge clk) begin : watch_beats
    pixel_result_t want;
    pixel_result_t got;
    if (!rst_n) begin
      gain_q = GAIN_W'(GAIN_RESET);
      expected_pixels.delete();
      pending <= 0;
    end else begin
      if (cfg_we)
        gain_q = cfg_saturation_gain;
      if (out_valid && !out_stall) begin
        got = '{out_red_out, out_green_out, out_blue_out, out_clipped};
        if (expected_pixels.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat with nothing expected: rgb %0d %0d %0d clip %0b",
                     $realtime, got.red, got.green, got.blue, got.clipped);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.clipped !== want.clipped) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: mismatch: expected rgb %0d %0d %0d clip %0b, ",
                        "got %0d %0d %0d clip %0b"},
                       $realtime, want.red, want.green, want.blue, want.clipped,
                       got.red, got.green, got.blue, got.clipped);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.insert(expected_pixels.size(),
                               adjust_pixel(in_red_in, in_green_in, in_blue_in, gain_q));
      pending <= expected_pixels.size();
    end
  end

endmodule

@@ sim/yuv_saturation_adjust_unit_tb.sv @@
// Testbench top for the saturation adjust unit: clock, reset, stimulus and verdict.
module yuv_saturation_adjust_unit_tb import ysa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_PIXELS = 90;
  localparam int HOLD_CYCLES  = 300;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [GAIN_W-1:0] cfg_saturation_gain;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_red_in;
  logic [7:0]        in_green_in;
  logic [7:0]        in_blue_in;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_red_out;
  logic [7:0]        out_green_out;
  logic [7:0]        out_blue_out;
  logic              out_clipped;

  int   mismatches;
  int   pending;
  logic steady;        // no idling on either side
  logic sink_stall;
  logic long_hold;
  logic hold_request;

  assign out_stall = sink_stall | long_hold;

  yuv_saturation_adjust_unit #(.PIXEL_BITS(8)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_saturation_gain (cfg_saturation_gain),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red_in           (in_red_in),
    .in_green_in         (in_green_in),
    .in_blue_in          (in_blue_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out),
    .out_clipped         (out_clipped)
  );

  saturation_adjust_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_saturation_gain (cfg_saturation_gain),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red_in           (in_red_in),
    .in_green_in         (in_green_in),
    .in_blue_in          (in_blue_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out),
    .out_clipped         (out_clipped),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall before each beat, none while steady
  initial begin : result_sink
    int n;
    sink_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = steady ? 0 : $urandom_range(0, 8);
      repeat (n) begin
        sink_stall <= 1'b1;
        @(posedge clk);
      end
      sink_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one long hold-off so the pipeline fills and backs up into the input
  initial begin : long_stall
    long_hold <= 1'b0;
    @(posedge clk iff hold_request);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    cfg_saturation_gain <= gain;
    cfg_we              <= 1'b1;
    @(posedge clk);
    cfg_we              <= 1'b0;
  endtask

  function automatic logic [7:0] near_rail();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
  endfunction

  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end
      4, 5: begin
        // corners of the color cube: primaries, secondaries, black, white
        r = {8{$urandom_range(0, 1) == 1}};
        g = {8{$urandom_range(0, 1) == 1}};
        b = {8{$urandom_range(0, 1) == 1}};
      end
      6, 7: begin
        r = 8'($urandom); g = r; b = r;
      end
      default: begin
        r = near_rail(); g = near_rail(); b = near_rail();
      end
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin : stimulus
    logic [GAIN_W-1:0] phase_gain[10];
    phase_gain = '{12'd256, 12'h7FF, 12'h800, 12'd0, 12'd256,
                   12'hF00, 12'd128, 12'd512, 12'h000, 12'h000};
    phase_gain[8] = GAIN_W'($urandom);
    phase_gain[9] = GAIN_W'($urandom);

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_saturation_gain <= '0;
    in_valid            <= 1'b0;
    in_red_in           <= '0;
    in_green_in         <= '0;
    in_blue_in          <= '0;
    steady              <= 1'b0;
    hold_request        <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, near-black, near-white, mid-gray and one mixed pixel at the reset gain
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd0,   8'd128);

    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        drain_results();
        write_gain(phase_gain[p]);
      end
      steady <= (p % 3 == 1) || (p == 3);
      if (p == 3)
        hold_request <= 1'b1;
      for (int i = 0; i < PHASE_PIXELS; i++)
        send_random_pixel();
    end
    drain_results();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
